FILE: design/daq_event_word_decoder_assert.svh
// assertion macros shared by the decoder modules
// each macro expects clk and arst_n in the scope where it is used
`ifndef DAQ_EVENT_WORD_DECODER_ASSERT_SVH
`define DAQ_EVENT_WORD_DECODER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DAQ_EWD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define DAQ_EWD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition must never hold
`define DAQ_EWD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

FILE: design/daq_ewd_pkg.sv
package daq_ewd_pkg;

	// sizing
	localparam int CHANNELS        = 2048;
	localparam int MAX_EVENT_WORDS = 1000;
	localparam int CH_W            = 11;
	localparam int VAL_W           = 16;
	localparam int TIME_W          = 33;
	localparam int CNT_W           = 48;
	localparam int KIND_DEPTH      = CHANNELS / 2;
	localparam int KIND_AW         = $clog2(KIND_DEPTH);
	localparam int CTR_AW          = $clog2(CHANNELS);
	localparam int WCNT_W          = $clog2(MAX_EVENT_WORDS + 1);

	// queues between the parts
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);
	localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);
	localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

	// stream marks
	localparam logic [31:0] END_MARK   = 32'hf000_0000;
	localparam logic [31:0] BEGIN_MASK = 32'he000_ffff;
	localparam logic [31:0] BEGIN_MARK = 32'he000_0000;

	// channel kinds held in the kind table
	typedef enum logic [2:0] {
		K_UNUSED = 3'd0,
		K_HIST   = 3'd1,
		K_CNT_LO = 3'd2,
		K_CNT_HI = 3'd3,
		K_TIME1  = 3'd4,
		K_TIME2  = 3'd5,
		K_TIME3  = 3'd6,
		K_TIME4  = 3'd7
	} kind_t;

	// operations passed from front to back
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOOKUP,
		OP_HIST,
		OP_CLO,
		OP_CHI,
		OP_TM1,
		OP_TM2,
		OP_TM3,
		OP_TM4,
		OP_CLOSE,
		OP_CLOSE_TR
	} op_t;

	// result kinds
	typedef enum logic [2:0] {
		RK_HIST      = 3'd0,
		RK_COUNTER   = 3'd1,
		RK_TIME      = 3'd2,
		RK_DATA_END  = 3'd3,
		RK_TIME_END  = 3'd4
	} res_kind_t;

	typedef struct packed {
		logic              action;
		logic [31:0]       word;
		logic [CH_W-1:0]   load_channel;
		logic [2:0]        load_kind;
	} item_t;

	typedef struct packed {
		logic [2:0]        result_kind;
		logic [CH_W-1:0]   channel;
		logic [31:0]       sample_value;
		logic [CNT_W-1:0]  counter_total;
		logic [TIME_W-1:0] time_seconds;
		logic [TIME_W-1:0] time_microseconds;
		logic [TIME_W-1:0] start_seconds;
		logic [TIME_W-1:0] start_microseconds;
		logic [CNT_W-1:0]  events_seen;
		logic [CNT_W-1:0]  data_events_seen;
		logic              truncated;
	} result_t;

	typedef struct packed {
		op_t              op;
		logic [CH_W-1:0]  addr;
		logic [VAL_W-1:0] val;
	} cmd_t;

	// one counter pair entry
	typedef struct packed {
		logic [CNT_W-1:0] total;
		logic [31:0]      reading;
	} ctr_t;

	// status seen by the front when deciding whether to take an item
	typedef struct packed {
		logic [CQ_CW-1:0] cq_count;
		logic             back_clearing;
	} front_stat_t;

	// saturating add at 2^33-1
	function automatic logic [TIME_W-1:0] sat_add33(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

FILE: design/daq_ewd_ram.sv
module daq_ewd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, registered read port (old data on collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/daq_ewd_front.sv
`include "daq_event_word_decoder_assert.svh"

module daq_ewd_front import daq_ewd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  item_t       item,
	input  front_stat_t stat,
	output logic        cq_push,
	output cmd_t        cq_cmd
);

	localparam logic [WCNT_W-1:0] MAX_WORDS_C = WCNT_W'(MAX_EVENT_WORDS);

	logic               clearing_q;
	logic [KIND_AW-1:0] clr_cnt_q;

	logic               accept;
	logic               stream;
	logic               load;
	logic [15:0]        ch16;
	logic               ch_ok;

	logic               inside_q, inside_d;
	logic               drop_q, drop_d;
	logic [WCNT_W-1:0]  wcnt_q, wcnt_d;
	op_t                pre_op;

	logic               we0, we1;
	logic [KIND_AW-1:0] wa0, wa1;
	logic [2:0]         wd0, wd1;
	logic [2:0]         rd0, rd1;
	logic               load_ok;
	logic               pair;

	logic               valid_s1;
	op_t                pre_op_s1;
	logic [CH_W-1:0]    ch_s1;
	logic [VAL_W-1:0]   val_s1;
	kind_t              kind_s1;

	// take an item only when every item in flight has a queue slot
	assign full = clearing_q || stat.back_clearing ||
		((CQ_CW + 1)'(stat.cq_count) + (CQ_CW + 1)'(valid_s1) >= (CQ_CW + 1)'(CQ_DEPTH));
	assign accept = push && !full;
	assign stream = accept && !item.action;
	assign load   = accept && item.action;
	assign ch16   = item.word[31:16];
	assign ch_ok  = int'(ch16) < CHANNELS;

	// event framing: skip to begin mark, word limit, drop to end mark
	always_comb begin
		inside_d = inside_q;
		drop_d   = drop_q;
		wcnt_d   = wcnt_q;
		pre_op   = OP_NONE;
		if (stream) begin
			if (item.word == END_MARK) begin
				inside_d = 1'b0;
				wcnt_d   = '0;
				if (drop_q) begin
					drop_d = 1'b0;
				end else begin
					pre_op = OP_CLOSE;
				end
			end else if (!drop_q) begin
				if (wcnt_q >= MAX_WORDS_C) begin
					pre_op   = OP_CLOSE_TR;
					drop_d   = 1'b1;
					inside_d = 1'b0;
					wcnt_d   = '0;
				end else begin
					wcnt_d = wcnt_q + WCNT_W'(1);
					if (!inside_q) begin
						if ((item.word & BEGIN_MASK) == BEGIN_MARK) begin
							inside_d = 1'b1;
						end
					end else if (ch_ok) begin
						pre_op = OP_LOOKUP;
					end
				end
			end
		end
	end

	// kind table writes: even and odd channels in separate banks
	assign load_ok = int'(item.load_channel) < CHANNELS;
	assign pair    = (kind_t'(item.load_kind) == K_CNT_LO) &&
		(int'(item.load_channel) + 1 < CHANNELS);

	always_comb begin
		we0 = 1'b0;
		we1 = 1'b0;
		wa0 = item.load_channel[KIND_AW:1];
		wa1 = item.load_channel[KIND_AW:1];
		wd0 = item.load_kind;
		wd1 = item.load_kind;
		if (clearing_q) begin
			we0 = 1'b1;
			we1 = 1'b1;
			wa0 = clr_cnt_q;
			wa1 = clr_cnt_q;
			wd0 = K_UNUSED;
			wd1 = K_UNUSED;
		end else if (load && load_ok) begin
			if (!item.load_channel[0]) begin
				we0 = 1'b1;
				we1 = pair;
				wd1 = K_CNT_HI;
			end else begin
				we1 = 1'b1;
				we0 = pair;
				wa0 = item.load_channel[KIND_AW:1] + KIND_AW'(1);
				wd0 = K_CNT_HI;
			end
		end
	end

	daq_ewd_ram #(.WIDTH(3), .DEPTH(KIND_DEPTH)) u_kind_even (
		.clk   (clk),
		.we    (we0),
		.waddr (wa0),
		.wdata (wd0),
		.re    (stream),
		.raddr (ch16[KIND_AW:1]),
		.rdata (rd0)
	);

	daq_ewd_ram #(.WIDTH(3), .DEPTH(KIND_DEPTH)) u_kind_odd (
		.clk   (clk),
		.we    (we1),
		.waddr (wa1),
		.wdata (wd1),
		.re    (stream),
		.raddr (ch16[KIND_AW:1]),
		.rdata (rd1)
	);

	// control state and kind table clearing after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			inside_q   <= 1'b0;
			drop_q     <= 1'b0;
			wcnt_q     <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + KIND_AW'(1);
				if (clr_cnt_q == KIND_AW'(KIND_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			inside_q <= inside_d;
			drop_q   <= drop_d;
			wcnt_q   <= wcnt_d;
			valid_s1 <= stream && (pre_op != OP_NONE);
		end
	end

	// lookup stage payload
	always_ff @(posedge clk) begin
		if (stream) begin
			pre_op_s1 <= pre_op;
			ch_s1     <= ch16[CH_W-1:0];
			val_s1    <= item.word[VAL_W-1:0];
		end
	end

	// classify by channel kind
	assign kind_s1 = kind_t'(ch_s1[0] ? rd1 : rd0);

	always_comb begin
		cq_cmd.op   = pre_op_s1;
		cq_cmd.addr = ch_s1;
		cq_cmd.val  = val_s1;
		if (pre_op_s1 == OP_LOOKUP) begin
			case (kind_s1)
				K_HIST:   cq_cmd.op = OP_HIST;
				K_CNT_LO: cq_cmd.op = OP_CLO;
				K_CNT_HI: begin
					// high half on channel zero has no low partner
					if (ch_s1 == '0) begin
						cq_cmd.op = OP_NONE;
					end else begin
						cq_cmd.op   = OP_CHI;
						cq_cmd.addr = ch_s1 - CH_W'(1);
					end
				end
				K_TIME1:  cq_cmd.op = OP_TM1;
				K_TIME2:  cq_cmd.op = OP_TM2;
				K_TIME3:  cq_cmd.op = OP_TM3;
				K_TIME4:  cq_cmd.op = OP_TM4;
				default:  cq_cmd.op = OP_NONE;
			endcase
		end
	end

	assign cq_push = valid_s1 && (cq_cmd.op != OP_NONE);

	`DAQ_EWD_ASSERT_IMP(a_drop_outside, drop_q, !inside_q, "dropping while inside an event")
	`DAQ_EWD_ASSERT_NXT(a_limit_drops, stream && !drop_q && (item.word != END_MARK) && (wcnt_q >= MAX_WORDS_C), drop_q, "word limit did not start dropping")

endmodule

FILE: design/daq_ewd_cmdq.sv
`include "daq_event_word_decoder_assert.svh"

module daq_ewd_cmdq import daq_ewd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cmd_t             wdata,
	input  logic             pop,
	output cmd_t             head,
	output logic [CQ_CW-1:0] count
);

	cmd_t             mem_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_CW-1:0] count_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + CQ_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + CQ_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CQ_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CQ_CW'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign count = count_q;

	`DAQ_EWD_ASSERT_NEVER(a_cq_overflow, push && !pop && (count_q == CQ_CW'(CQ_DEPTH)), "command queue overflow")
	`DAQ_EWD_ASSERT_NEVER(a_cq_underflow, pop && (count_q == '0), "command queue underflow")

endmodule

FILE: design/daq_ewd_back.sv
`include "daq_event_word_decoder_assert.svh"

module daq_ewd_back import daq_ewd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             head,
	input  logic [CQ_CW-1:0] cq_count,
	output logic             cq_pop,
	output logic             clearing,
	output logic             empty,
	input  logic             pop,
	output result_t          result
);

	logic               clearing_q;
	logic [CTR_AW-1:0]  clr_cnt_q;

	logic               valid_s1;
	cmd_t               cmd_s1;
	logic               fwd_s1;
	ctr_t               fwd_data_s1;

	ctr_t               ram_dout;
	ctr_t               base;
	ctr_t               ctr_new;
	logic               ctr_we;
	logic               ram_we;
	logic [CTR_AW-1:0]  ram_waddr;
	ctr_t               ram_wdata;

	logic [TIME_W-1:0]  bsec_q, bsec_d;
	logic [TIME_W-1:0]  bmic_q, bmic_d;
	logic [TIME_W-1:0]  csec_q, csec_d;
	logic [TIME_W-1:0]  cmic_q, cmic_d;
	logic [TIME_W-1:0]  fsec_q, fsec_d;
	logic [TIME_W-1:0]  fmic_q, fmic_d;
	logic [CNT_W-1:0]   ev_q, ev_d;
	logic [CNT_W-1:0]   dev_q, dev_d;

	result_t            res;
	logic               rq_push;
	logic               rq_pop;
	result_t            rq_mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0]   rq_wr_q;
	logic [RQ_AW-1:0]   rq_rd_q;
	logic [RQ_CW-1:0]   rq_count_q;

	// pop a command only when its result is sure to find a slot
	assign cq_pop = !clearing_q && (cq_count != '0) &&
		((RQ_CW + 1)'(rq_count_q) + (RQ_CW + 1)'(valid_s1) < (RQ_CW + 1)'(RQ_DEPTH));
	assign clearing = clearing_q;

	// counter pair memory, read at pop, written back in the cycle after
	assign ram_we    = clearing_q || ctr_we;
	assign ram_waddr = clearing_q ? clr_cnt_q : cmd_s1.addr[CTR_AW-1:0];
	assign ram_wdata = clearing_q ? '0 : ctr_new;

	daq_ewd_ram #(.WIDTH($bits(ctr_t)), .DEPTH(CHANNELS)) u_ctr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cq_pop),
		.raddr (head.addr[CTR_AW-1:0]),
		.rdata (ram_dout)
	);

	// bypass the write that lands on the same edge as the read
	assign base = fwd_s1 ? fwd_data_s1 : ram_dout;

	// execute one command
	always_comb begin
		ctr_we  = 1'b0;
		ctr_new = base;
		bsec_d  = bsec_q;
		bmic_d  = bmic_q;
		csec_d  = csec_q;
		cmic_d  = cmic_q;
		fsec_d  = fsec_q;
		fmic_d  = fmic_q;
		ev_d    = ev_q;
		dev_d   = dev_q;
		rq_push = 1'b0;
		res     = '0;
		if (valid_s1) begin
			case (cmd_s1.op)
				OP_HIST: begin
					rq_push           = 1'b1;
					res.result_kind   = RK_HIST;
					res.channel       = cmd_s1.addr;
					res.sample_value  = 32'(cmd_s1.val);
				end
				OP_CLO: begin
					ctr_we          = 1'b1;
					ctr_new.total   = base.total + CNT_W'(cmd_s1.val);
					ctr_new.reading = 32'(cmd_s1.val);
				end
				OP_CHI: begin
					ctr_we            = 1'b1;
					ctr_new.total     = base.total + CNT_W'({cmd_s1.val, 16'h0000});
					ctr_new.reading   = base.reading + {cmd_s1.val, 16'h0000};
					rq_push           = 1'b1;
					res.result_kind   = RK_COUNTER;
					res.channel       = cmd_s1.addr;
					res.sample_value  = ctr_new.reading;
					res.counter_total = ctr_new.total;
				end
				OP_TM1: bmic_d = sat_add33(bmic_q, TIME_W'(cmd_s1.val));
				OP_TM2: bmic_d = sat_add33(bmic_q, TIME_W'({cmd_s1.val, 16'h0000}));
				OP_TM3: bsec_d = sat_add33(bsec_q, TIME_W'(cmd_s1.val));
				OP_TM4: begin
					bsec_d          = sat_add33(bsec_q, TIME_W'({cmd_s1.val, 16'h0000}));
					rq_push         = 1'b1;
					res.result_kind = RK_TIME;
				end
				OP_CLOSE, OP_CLOSE_TR: begin
					ev_d = ev_q + CNT_W'(1);
					if ((bsec_q == '0) && (bmic_q == '0)) begin
						dev_d           = dev_q + CNT_W'(1);
						res.result_kind = RK_DATA_END;
					end else begin
						csec_d = bsec_q;
						cmic_d = bmic_q;
						// first time mark fixes the start time
						if ((fsec_q == '0) && (fmic_q == '0)) begin
							fsec_d = bsec_q;
							fmic_d = bmic_q;
						end
						res.result_kind = RK_TIME_END;
					end
					bsec_d        = '0;
					bmic_d        = '0;
					rq_push       = 1'b1;
					res.truncated = (cmd_s1.op == OP_CLOSE_TR);
				end
				default: ;
			endcase
		end
		// fields common to every result
		if (cmd_s1.op == OP_TM4) begin
			res.time_seconds      = bsec_d;
			res.time_microseconds = bmic_d;
		end else begin
			res.time_seconds      = csec_d;
			res.time_microseconds = cmic_d;
		end
		res.start_seconds      = fsec_d;
		res.start_microseconds = fmic_d;
		res.events_seen        = ev_d;
		res.data_events_seen   = dev_d;
	end

	// control and model state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			valid_s1   <= 1'b0;
			bsec_q     <= '0;
			bmic_q     <= '0;
			csec_q     <= '0;
			cmic_q     <= '0;
			fsec_q     <= '0;
			fmic_q     <= '0;
			ev_q       <= '0;
			dev_q      <= '0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + CTR_AW'(1);
				if (clr_cnt_q == CTR_AW'(CHANNELS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			valid_s1 <= cq_pop;
			bsec_q   <= bsec_d;
			bmic_q   <= bmic_d;
			csec_q   <= csec_d;
			cmic_q   <= cmic_d;
			fsec_q   <= fsec_d;
			fmic_q   <= fmic_d;
			ev_q     <= ev_d;
			dev_q    <= dev_d;
		end
	end

	// execute stage payload and bypass capture
	always_ff @(posedge clk) begin
		if (cq_pop) begin
			cmd_s1      <= head;
			fwd_s1      <= ctr_we && (cmd_s1.addr == head.addr);
			fwd_data_s1 <= ctr_new;
		end
	end

	// result queue
	assign rq_pop = pop && (rq_count_q != '0);
	assign empty  = (rq_count_q == '0);
	assign result = rq_mem_q[rq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q    <= '0;
			rq_rd_q    <= '0;
			rq_count_q <= '0;
		end else begin
			if (rq_push) begin
				rq_wr_q <= (rq_wr_q == RQ_AW'(RQ_DEPTH - 1)) ? '0 : rq_wr_q + RQ_AW'(1);
			end
			if (rq_pop) begin
				rq_rd_q <= (rq_rd_q == RQ_AW'(RQ_DEPTH - 1)) ? '0 : rq_rd_q + RQ_AW'(1);
			end
			if (rq_push && !rq_pop) begin
				rq_count_q <= rq_count_q + RQ_CW'(1);
			end else if (rq_pop && !rq_push) begin
				rq_count_q <= rq_count_q - RQ_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rq_push) begin
			rq_mem_q[rq_wr_q] <= res;
		end
	end

	`DAQ_EWD_ASSERT_NEVER(a_rq_overflow, rq_push && !rq_pop && (rq_count_q == RQ_CW'(RQ_DEPTH)), "result queue overflow")
	`DAQ_EWD_ASSERT_IMP(a_idle_in_clear, clearing_q, !valid_s1, "command executed during memory clear")

endmodule

FILE: design/daq_event_word_decoder.sv
// Acquisition word decoder. Data words (action 0) are skipped until a begin mark, then split
// into channel and value and handled by the kind of their channel: histogram samples,
// completed counter pairs and the last of the four time words each give one result; an end
// mark or the word limit closes the event as a data event or a time mark. Load items
// (action 1) write the channel kind table, which a later data word sees at once. One item is
// taken per clock when results are popped as they come; a result passes the kind table read,
// the command queue, the registered read of the counter pair memory and the result queue
// before it appears on the ports. After reset full stays high while the counter memory and
// the kind table are cleared.
module daq_event_word_decoder import daq_ewd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic             cq_push;
	cmd_t             cq_cmd;
	logic             cq_pop;
	cmd_t             cq_head;
	logic [CQ_CW-1:0] cq_count;
	logic             back_clearing;
	front_stat_t      stat;

	assign stat.cq_count      = cq_count;
	assign stat.back_clearing = back_clearing;

	// framing and kind lookup
	daq_ewd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.stat    (stat),
		.cq_push (cq_push),
		.cq_cmd  (cq_cmd)
	);

	// decoupling queue
	daq_ewd_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cq_push),
		.wdata  (cq_cmd),
		.pop    (cq_pop),
		.head   (cq_head),
		.count  (cq_count)
	);

	// counters, time and event bookkeeping
	daq_ewd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (cq_head),
		.cq_count (cq_count),
		.cq_pop   (cq_pop),
		.clearing (back_clearing),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

FILE: test/daq_event_word_decoder_test.sv
`timescale 1ns / 1ps

module daq_event_word_decoder_test;
	import daq_ewd_pkg::*;

	localparam int RANDOM_ITEMS = 100;
	localparam int QUIET_ITEMS  = 30;
	localparam int SKIP_WORDS   = 400;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 8;
	localparam int POOL_SIZE    = 16;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    push   = 1'b0;
	logic    pop    = 1'b0;
	item_t   item   = '0;
	logic    full;
	logic    empty;
	result_t result;

	daq_event_word_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #2 clk = ~clk;

	// items waiting to go in, results waiting to come out
	item_t   words_to_send [$];
	result_t results_due [$];

	// mirror of the decoder state
	kind_t             kind_tab [CHANNELS];
	logic [CNT_W-1:0]  pair_total [CHANNELS];
	logic [31:0]       pair_reading [CHANNELS];
	logic              in_event;
	logic              dropping;
	int unsigned       word_count;
	logic [TIME_W-1:0] buf_sec, buf_usec, cur_sec, cur_usec, first_sec, first_usec;
	logic [CNT_W-1:0]  n_events, n_data_events;

	// handshake bookkeeping
	bit sent_taken;
	bit quiet_tail;
	bit long_hold_wanted;
	bit long_hold_done;
	int send_gap;
	int pop_hold;

	// run statistics
	int mismatches;
	int n_accepted;
	int n_results;
	int n_loads;
	int n_time_marks;
	int n_truncated;
	int rand_items;

	// channels most stimulus is aimed at, pairs and range ends among them
	logic [CH_W-1:0] chan_pool [POOL_SIZE] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11,
		1023, 1024, 2046, 2047};

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("tb: mismatch at %0t: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
		input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic compare_result(input result_t got, input result_t want);
		check_field("result_kind", 64'(got.result_kind), 64'(want.result_kind));
		check_field("channel", 64'(got.channel), 64'(want.channel));
		check_field("sample_value", 64'(got.sample_value), 64'(want.sample_value));
		check_field("counter_total", 64'(got.counter_total), 64'(want.counter_total));
		check_field("time_seconds", 64'(got.time_seconds), 64'(want.time_seconds));
		check_field("time_microseconds", 64'(got.time_microseconds),
			64'(want.time_microseconds));
		check_field("start_seconds", 64'(got.start_seconds), 64'(want.start_seconds));
		check_field("start_microseconds", 64'(got.start_microseconds),
			64'(want.start_microseconds));
		check_field("events_seen", 64'(got.events_seen), 64'(want.events_seen));
		check_field("data_events_seen", 64'(got.data_events_seen),
			64'(want.data_events_seen));
		check_field("truncated", 64'(got.truncated), 64'(want.truncated));
	endtask

	// saturating time sum
	function automatic logic [TIME_W-1:0] time_add(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
	endfunction

	// fields every result carries from the current state
	function automatic result_t base_result(input res_kind_t k);
		result_t r;
		r = '0;
		r.result_kind        = k;
		r.time_seconds       = cur_sec;
		r.time_microseconds  = cur_usec;
		r.start_seconds      = first_sec;
		r.start_microseconds = first_usec;
		r.events_seen        = n_events;
		r.data_events_seen   = n_data_events;
		return r;
	endfunction

	// close the open event as a data event or a time mark
	task automatic close_event(input logic trunc);
		result_t r;
		res_kind_t k;
		n_events++;
		if (buf_sec == 0 && buf_usec == 0) begin
			n_data_events++;
			k = RK_DATA_END;
		end else begin
			cur_sec  = buf_sec;
			cur_usec = buf_usec;
			if (first_sec == 0 && first_usec == 0) begin
				first_sec  = cur_sec;
				first_usec = cur_usec;
			end
			k = RK_TIME_END;
			n_time_marks++;
		end
		buf_sec    = '0;
		buf_usec   = '0;
		in_event   = 1'b0;
		word_count = 0;
		r = base_result(k);
		r.truncated = trunc;
		if (trunc)
			n_truncated++;
		results_due.push_back(r);
	endtask

	// expected effect of one accepted item
	task automatic decode_item(input item_t it);
		logic [15:0]     ch;
		logic [15:0]     val;
		logic [CH_W-1:0] lo;
		result_t         r;
		if (it.action) begin
			n_loads++;
			kind_tab[it.load_channel] = kind_t'(it.load_kind);
			if (kind_t'(it.load_kind) == K_CNT_LO && int'(it.load_channel) + 1 < CHANNELS)
				kind_tab[it.load_channel + CH_W'(1)] = K_CNT_HI;
			return;
		end
		if (it.word == END_MARK) begin
			if (dropping) begin
				dropping   = 1'b0;
				in_event   = 1'b0;
				word_count = 0;
			end else begin
				close_event(1'b0);
			end
			return;
		end
		if (dropping)
			return;
		if (word_count >= MAX_EVENT_WORDS) begin
			close_event(1'b1);
			dropping = 1'b1;
			return;
		end
		word_count++;
		if (!in_event) begin
			if ((it.word & BEGIN_MASK) == BEGIN_MARK)
				in_event = 1'b1;
			return;
		end
		ch  = it.word[31:16];
		val = it.word[15:0];
		if (ch >= CHANNELS)
			return;
		case (kind_tab[ch[CH_W-1:0]])
			K_HIST: begin
				r = base_result(RK_HIST);
				r.channel      = ch[CH_W-1:0];
				r.sample_value = 32'(val);
				results_due.push_back(r);
			end
			K_CNT_LO: begin
				pair_total[ch]   = pair_total[ch] + CNT_W'(val);
				pair_reading[ch] = 32'(val);
			end
			K_CNT_HI: begin
				// channel zero has no low partner
				if (ch != 0) begin
					lo = CH_W'(ch - 16'd1);
					pair_total[lo]   = pair_total[lo] + CNT_W'({val, 16'h0000});
					pair_reading[lo] = pair_reading[lo] + {val, 16'h0000};
					r = base_result(RK_COUNTER);
					r.channel       = lo;
					r.sample_value  = pair_reading[lo];
					r.counter_total = pair_total[lo];
					results_due.push_back(r);
				end
			end
			K_TIME1: buf_usec = time_add(buf_usec, TIME_W'(val));
			K_TIME2: buf_usec = time_add(buf_usec, TIME_W'({val, 16'h0000}));
			K_TIME3: buf_sec  = time_add(buf_sec, TIME_W'(val));
			K_TIME4: begin
				buf_sec = time_add(buf_sec, TIME_W'({val, 16'h0000}));
				r = base_result(RK_TIME);
				r.time_seconds      = buf_sec;
				r.time_microseconds = buf_usec;
				results_due.push_back(r);
			end
			default: ;
		endcase
	endtask

	// check results, then account for the item taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				n_results++;
				if (results_due.size() == 0)
					report_mismatch("result with nothing expected");
				else
					compare_result(result, results_due.pop_front());
			end
			sent_taken = push && !full;
			if (sent_taken) begin
				decode_item(item);
				void'(words_to_send.pop_front());
				n_accepted++;
			end
		end
	end

	// sender: offers the head of the queue, with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && !sent_taken) begin
			// offer not taken yet, keep it
		end else if (send_gap > 0) begin
			send_gap--;
			push <= 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
			send_gap = $urandom_range(1, 15) - 1;
			push <= 1'b0;
		end else if (words_to_send.size() != 0) begin
			push <= 1'b1;
			item <= words_to_send[0];
		end else begin
			push <= 1'b0;
		end
	end

	// receiver: pops with random stalls and one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold > 0) begin
			pop_hold--;
			pop <= 1'b0;
		end else if (long_hold_wanted && !long_hold_done) begin
			long_hold_done = 1'b1;
			pop_hold = HOLD_CYCLES - 1;
			pop <= 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
			pop_hold = $urandom_range(1, 15) - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic send_word(input logic [31:0] w);
		item_t it;
		it.action       = 1'b0;
		it.word         = w;
		it.load_channel = CH_W'($urandom);
		it.load_kind    = 3'($urandom);
		words_to_send.push_back(it);
	endtask

	task automatic send_load(input logic [CH_W-1:0] ch, input kind_t k);
		item_t it;
		it.action       = 1'b1;
		it.word         = $urandom;
		it.load_channel = ch;
		it.load_kind    = k;
		words_to_send.push_back(it);
	endtask

	// let everything queued go through and the pipeline settle
	task automatic wait_drained();
		while (words_to_send.size() != 0 || push || results_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// one word inside an event, mostly aimed at the channel pool
	function automatic logic [31:0] event_word();
		case ($urandom_range(0, 19))
			0: return {16'($urandom_range(CHANNELS, 16'hffff)), rand_value()};
			1: return ($urandom & ~BEGIN_MASK) | BEGIN_MARK;
			2: return $urandom;
			default: return {5'b00000, chan_pool[$urandom_range(0, POOL_SIZE - 1)],
				rand_value()};
		endcase
	endfunction

	initial begin
		int n;
		int pick;
		for (int i = 0; i < CHANNELS; i++) begin
			kind_tab[i]     = K_UNUSED;
			pair_total[i]   = '0;
			pair_reading[i] = '0;
		end
		in_event      = 1'b0;
		dropping      = 1'b0;
		word_count    = 0;
		buf_sec       = '0;
		buf_usec      = '0;
		cur_sec       = '0;
		cur_usec      = '0;
		first_sec     = '0;
		first_usec    = '0;
		n_events      = '0;
		n_data_events = '0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// directed: end mark before any begin, every kind, range ends, saturation
		send_word(END_MARK);
		send_load(CH_W'(1), K_HIST);
		send_load(CH_W'(4), K_CNT_LO);
		send_load(CH_W'(0), K_CNT_HI);
		send_load(CH_W'(8), K_TIME1);
		send_load(CH_W'(9), K_TIME2);
		send_load(CH_W'(10), K_TIME3);
		send_load(CH_W'(11), K_TIME4);
		send_load(CH_W'(2047), K_CNT_LO);
		send_load(CH_W'(2), K_UNUSED);
		send_word(32'h0001_1234);
		send_word(BEGIN_MARK);
		send_word(32'h0001_ffff);
		send_word(32'h0001_0000);
		send_word(32'h0002_5555);
		send_word(32'h0000_ffff);
		send_word(32'h0004_ffff);
		send_word(32'h0005_ffff);
		send_word(32'hffff_ffff);
		send_word(32'he123_0000);
		send_word(32'h0008_ffff);
		send_word(32'h0009_ffff);
		send_word(32'h000a_ffff);
		repeat (3) send_word(32'h000b_ffff);
		send_word(32'h07ff_ffff);
		send_word(END_MARK);
		wait_drained();

		// receiver holds off while a burst of samples fills the block
		send_load(CH_W'(1), K_HIST);
		long_hold_wanted = 1'b1;
		send_word(BEGIN_MARK);
		repeat (80) send_word({16'h0001, 16'($urandom)});
		send_word(END_MARK);
		wait_drained();

		// word limit reached by skipped words plus an event that holds time information
		send_load(CH_W'(8), K_TIME1);
		repeat (SKIP_WORDS) send_word($urandom | 32'h1);
		send_word(BEGIN_MARK);
		send_word(32'h0008_0005);
		repeat (MAX_EVENT_WORDS - SKIP_WORDS - 2) send_word(event_word());
		repeat (4) send_word(event_word());
		send_word(END_MARK);
		wait_drained();

		// random events, loads, noise and broken events
		while (rand_items < RANDOM_ITEMS) begin
			if (rand_items > RANDOM_ITEMS - QUIET_ITEMS)
				quiet_tail = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				if ($urandom_range(0, 4) == 0)
					send_load(CH_W'($urandom), kind_t'($urandom_range(0, 7)));
				else
					send_load(chan_pool[$urandom_range(0, POOL_SIZE - 1)],
						kind_t'($urandom_range(0, 7)));
				rand_items++;
			end else if (pick < 20) begin
				if ($urandom_range(0, 1) == 0)
					send_word(END_MARK);
				else
					send_word($urandom);
				rand_items++;
			end else begin
				n = $urandom_range(0, 12);
				send_word(($urandom & ~BEGIN_MASK) | BEGIN_MARK);
				repeat (n) send_word(event_word());
				if ($urandom_range(0, 19) != 0)
					send_word(END_MARK);
				rand_items += n + 2;
			end
			while (words_to_send.size() > 64)
				@(negedge clk);
		end
		wait_drained();

		$display("tb: %0d items taken (%0d table loads), %0d results checked",
			n_accepted, n_loads, n_results);
		$display("tb: %0d events closed, %0d time marks, %0d cut at the word limit",
			n_events, n_time_marks, n_truncated);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// overall time limit
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/daq_ewd_pkg.sv
design/daq_ewd_ram.sv
design/daq_ewd_front.sv
design/daq_ewd_cmdq.sv
design/daq_ewd_back.sv
design/daq_event_word_decoder.sv
test/daq_event_word_decoder_test.sv
